// ===== rtl/core/gctm_pkg.sv =====
// ----------------------------------------------------------------------------
// gctm_pkg - shared types for the gamepad chord and turbo mapper
// Transaction layouts of the request and response streams, pad bit order.
// ----------------------------------------------------------------------------
package gctm_pkg;

   localparam int unsigned PadWidth     = 8;
   localparam int unsigned HoldWidth    = 16;
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned TurboWidth   = 8;
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 24;

   localparam logic [HoldWidth-1:0] ExitHoldReset = 16'd1000;

   // forwarded pad bit positions
   localparam int unsigned PadUp     = 0;
   localparam int unsigned PadDown   = 1;
   localparam int unsigned PadLeft   = 2;
   localparam int unsigned PadRight  = 3;
   localparam int unsigned PadSelect = 4;
   localparam int unsigned PadStart  = 5;
   localparam int unsigned PadA      = 6;
   localparam int unsigned PadB      = 7;

   // request transaction, lowest bit last
   typedef struct packed {
      logic [5:0]           fill;
      logic [TimeWidth-1:0] now_ms;
      logic                 btn_d;
      logic                 btn_c;
      logic                 btn_b;
      logic                 btn_a;
      logic                 btn_start;
      logic                 btn_select;
      logic                 btn_right;
      logic                 btn_left;
      logic                 btn_down;
      logic                 btn_up;
   } req_payload_type;

   // response transaction, lowest bit last
   typedef struct packed {
      logic [4:0]          fill;
      logic                quit_request;
      logic                load_request;
      logic                save_request;
      logic [PadWidth-1:0] pad_changed;
      logic [PadWidth-1:0] pad_state;
   } rsp_payload_type;

endpackage

// ===== rtl/core/gamepad_chord_turbo_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// gamepad_chord_turbo_mapper_unit - chord decode and turbo for a ten-button pad
// Forwards eight pads, pulses save/load/quit requests, runs turbo on C and D.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  req     | in  | req_tvalid/tready    | req_tdata  : 10 buttons, now_ms
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata  : pads, changed, pulses
//  csr     | in  | csr_valid/csr_ready  | csr_data   : exit_hold_ms
//
//  One poll per cycle sustained while req_tready is high; each result is
//  registered and presented from the response register.
//  All chord, turbo and exit-timer state moves in the same cycle as the
//  request transaction, so back-to-back polls see each other's effect.
//  A skid register behind the response register absorbs one result in a stall;
//  req_tready is a flop and drops only while the skid register is full.
//  Synchronous active-high reset; exit_hold_ms returns to 1000 ms.
//  csr_ready is always high.
//
module gamepad_chord_turbo_mapper_unit #(
   parameter int unsigned TURBO_HALF_PERIOD = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] btn_up [1] btn_down [2] btn_left [3] btn_right [4] btn_select
   // [5] btn_start [6] btn_a [7] btn_b [8] btn_c [9] btn_d [41:10] now_ms
   input  logic [gctm_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] pad_state [15:8] pad_changed [16] save_request
   // [17] load_request [18] quit_request
   output logic [gctm_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gctm_pkg::HoldWidth-1:0]        csr_data
);

   // turbo phase per frame count: high in the first half of each period
   function automatic logic [255:0] build_phase_lut();
      logic [255:0] lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = (((i / TURBO_HALF_PERIOD) % 2) == 0);
      end
      return lut;
   endfunction

   localparam logic [255:0] TURBO_PHASE_LUT = build_phase_lut();

   gctm_pkg::req_payload_type req;
   gctm_pkg::rsp_payload_type rsp_new;

   logic [gctm_pkg::HoldWidth-1:0]  exit_hold_ff;
   logic [gctm_pkg::PadWidth-1:0]   pad_ff,        pad_in;
   logic                            save_seen_ff,  save_seen_in;
   logic                            load_seen_ff,  load_seen_in;
   logic                            exit_seen_ff,  exit_seen_in;
   logic                            latched_ff,    latched_in;
   logic [gctm_pkg::TurboWidth-1:0] turbo_a_ff,    turbo_a_in;
   logic [gctm_pkg::TurboWidth-1:0] turbo_b_ff,    turbo_b_in;
   logic [gctm_pkg::TimeWidth-1:0]  exit_start_ff, exit_start_in;

   logic                            out_valid_ff,  out_valid_in;
   gctm_pkg::rsp_payload_type       out_data_ff,   out_data_in;
   logic                            skid_valid_ff, skid_valid_in;
   gctm_pkg::rsp_payload_type       skid_data_ff,  skid_data_in;
   logic                            ready_ff,      ready_in;

   logic                            accept;
   logic                            ex, sv, ld, fire;
   logic                            hold_a, hold_b, phase_a, phase_b;
   logic [gctm_pkg::TimeWidth-1:0]  elapsed;
   logic [gctm_pkg::PadWidth-1:0]   want, changed;

   assign req       = gctm_pkg::req_payload_type'(req_tdata);
   assign accept    = req_tvalid && ready_ff;
   assign csr_ready = 1'b1;

   // chord decode: exit wins over save and load whatever C and D do
   always_comb begin
      ex = req.btn_select && req.btn_start;
      sv = req.btn_select && req.btn_c && !req.btn_d && !req.btn_start;
      ld = req.btn_select && req.btn_d && !req.btn_c && !req.btn_start;
   end

   // exit timer: wrapping elapsed time against the hold setting
   assign elapsed = req.now_ms - exit_start_ff;
   assign fire    = ex && exit_seen_ff && !latched_ff &&
                    (elapsed >= {{(gctm_pkg::TimeWidth-gctm_pkg::HoldWidth){1'b0}},
                                 exit_hold_ff});

   // turbo: a button eaten by a chord counts as released
   always_comb begin
      hold_a  = req.btn_c && !sv && !ex;
      hold_b  = req.btn_d && !ld && !ex;
      phase_a = hold_a && TURBO_PHASE_LUT[turbo_a_ff];
      phase_b = hold_b && TURBO_PHASE_LUT[turbo_b_ff];
   end

   always_comb begin
      want = '0;
      want[gctm_pkg::PadUp]     = req.btn_up;
      want[gctm_pkg::PadDown]   = req.btn_down;
      want[gctm_pkg::PadLeft]   = req.btn_left;
      want[gctm_pkg::PadRight]  = req.btn_right;
      want[gctm_pkg::PadSelect] = req.btn_select && !sv && !ld && !ex;
      want[gctm_pkg::PadStart]  = req.btn_start && !ex;
      want[gctm_pkg::PadA]      = req.btn_a || phase_a;
      want[gctm_pkg::PadB]      = req.btn_b || phase_b;
   end

   // next state for one poll
   always_comb begin
      save_seen_in  = sv;
      load_seen_in  = ld;
      exit_seen_in  = ex;
      exit_start_in = ex ? (exit_seen_ff ? exit_start_ff : req.now_ms) : '0;
      latched_in    = latched_ff || fire;
      turbo_a_in    = turbo_a_ff;
      turbo_b_in    = turbo_b_ff;
      if (fire) begin
         // quit poll: drop every pad, report the ones that fell
         pad_in  = '0;
         changed = pad_ff;
      end else if (latched_ff) begin
         // frozen after quit
         pad_in  = pad_ff;
         changed = '0;
      end else begin
         pad_in     = want;
         changed    = want ^ pad_ff;
         turbo_a_in = hold_a ? turbo_a_ff + 1'b1 : '0;
         turbo_b_in = hold_b ? turbo_b_ff + 1'b1 : '0;
      end
   end

   always_comb begin
      rsp_new              = '0;
      rsp_new.pad_state    = pad_in;
      rsp_new.pad_changed  = changed;
      rsp_new.save_request = sv && !save_seen_ff;
      rsp_new.load_request = ld && !load_seen_ff;
      rsp_new.quit_request = fire;
   end

   // response register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end
      ready_in = !skid_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exit_hold_ff  <= gctm_pkg::ExitHoldReset;
         pad_ff        <= '0;
         save_seen_ff  <= 1'b0;
         load_seen_ff  <= 1'b0;
         exit_seen_ff  <= 1'b0;
         latched_ff    <= 1'b0;
         turbo_a_ff    <= '0;
         turbo_b_ff    <= '0;
         exit_start_ff <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         ready_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            exit_hold_ff <= csr_data;
         end
         if (accept) begin
            pad_ff        <= pad_in;
            save_seen_ff  <= save_seen_in;
            load_seen_ff  <= load_seen_in;
            exit_seen_ff  <= exit_seen_in;
            latched_ff    <= latched_in;
            turbo_a_ff    <= turbo_a_in;
            turbo_b_ff    <= turbo_b_in;
            exit_start_ff <= exit_start_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         ready_ff      <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/core/gctm_checker.sv =====
// ----------------------------------------------------------------------------
// gctm_checker - port-level checks for the gamepad chord and turbo mapper
// Checks responses for reset, quit freeze, change mask, save/load, stalls.
// ----------------------------------------------------------------------------
module gctm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [gctm_pkg::RspDataWidth-1:0] rsp_tdata
);

   gctm_pkg::rsp_payload_type     rsp;
   logic                          rsp_take;
   logic                          quit_seen_ff, quit_seen_in;
   logic [gctm_pkg::PadWidth-1:0] last_pad_ff,  last_pad_in;

   assign rsp      = gctm_pkg::rsp_payload_type'(rsp_tdata);
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      quit_seen_in = quit_seen_ff || (rsp_take && rsp.quit_request);
      last_pad_in  = rsp_take ? rsp.pad_state : last_pad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quit_seen_ff <= 1'b0;
         last_pad_ff  <= '0;
      end else begin
         quit_seen_ff <= quit_seen_in;
         last_pad_ff  <= last_pad_in;
      end
   end

   // response channel comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // change mask always equals pad_state XOR the previous delivered pad state
   a_changed_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp.pad_changed == (rsp.pad_state ^ last_pad_ff)))
      else $error("pad_changed disagrees with pad_state history");

   // after quit the pads stay released and quit never repeats
   a_quit_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && quit_seen_ff) |->
         (rsp.pad_state == '0 && rsp.pad_changed == '0 && !rsp.quit_request))
      else $error("output not frozen after quit");

   // save and load chords exclude each other
   a_save_load_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.save_request && rsp.load_request))
      else $error("save and load requested together");

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind gamepad_chord_turbo_mapper_unit gctm_checker u_gctm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/gamepad_chord_turbo_mapper_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gamepad_chord_turbo_mapper_unit_tb - self-checking bench for the pad mapper
// Streams polls into the mapper, predicts every report in step with the
// stimulus, and checks each response transaction field by field. Runs
// through several exit hold times, sender gaps, receiver stalls and one long
// back-pressure stretch. The exit latch is only taken near the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gamepad_chord_turbo_mapper_unit_tb;

   localparam int unsigned TurboHalf     = 2;
   localparam int unsigned HoldOffCycles = 400;   // long receiver hold-off
   localparam int unsigned WatchdogLimit = 3000;  // cycles with no transaction
   localparam int unsigned ReportLimit   = 10;

   // button positions in the poll beyond the eight forwarded pads
   localparam int unsigned BtnC = 8;
   localparam int unsigned BtnD = 9;

   localparam logic [9:0] MaskSelect = 10'(1 << gctm_pkg::PadSelect);
   localparam logic [9:0] MaskStart  = 10'(1 << gctm_pkg::PadStart);
   localparam logic [9:0] MaskC      = 10'(1 << BtnC);
   localparam logic [9:0] MaskD      = 10'(1 << BtnD);
   localparam logic [9:0] MaskB      = 10'(1 << gctm_pkg::PadB);
   localparam logic [9:0] MaskDirs   = 10'((1 << gctm_pkg::PadUp) |
                                           (1 << gctm_pkg::PadDown) |
                                           (1 << gctm_pkg::PadLeft) |
                                           (1 << gctm_pkg::PadRight));
   localparam logic [9:0] MaskAB     = 10'((1 << gctm_pkg::PadA) | (1 << gctm_pkg::PadB));
   localparam logic [9:0] MaskAll    = 10'h3FF;

   // mirror of everything the mapper remembers between polls
   typedef struct packed {
      logic [gctm_pkg::HoldWidth-1:0]  hold;
      logic [gctm_pkg::PadWidth-1:0]   pads;
      logic                            save_seen;
      logic                            load_seen;
      logic                            exit_seen;
      logic                            latched;
      logic [gctm_pkg::TurboWidth-1:0] turbo_a;
      logic [gctm_pkg::TurboWidth-1:0] turbo_b;
      logic [gctm_pkg::TimeWidth-1:0]  exit_t0;
   } mapper_state_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [gctm_pkg::ReqDataWidth-1:0] req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [gctm_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [gctm_pkg::HoldWidth-1:0]    csr_data   = '0;

   gctm_pkg::req_payload_type      pending_polls[$];     // polls not yet offered
   gctm_pkg::rsp_payload_type      expected_reports[$];  // predicted, oldest first
   mapper_state_type               pad_model;
   logic [gctm_pkg::TimeWidth-1:0] poll_time;

   int unsigned send_idle_pct    = 0;
   int unsigned recv_stall_pct   = 0;
   logic        hold_off_request = 1'b0;
   logic        hold_off_done    = 1'b0;
   int unsigned hold_off_left    = 0;
   int unsigned idle_cycles      = 0;

   int unsigned polls_sent      = 0;
   int unsigned reports_checked = 0;
   int unsigned mismatches      = 0;
   int unsigned settings_used   = 1;   // the reset value counts as one
   int unsigned save_pulses     = 0;
   int unsigned load_pulses     = 0;
   int unsigned quit_pulses     = 0;

   always #5 clock = ~clock;

   gamepad_chord_turbo_mapper_unit #(
      .TURBO_HALF_PERIOD(TurboHalf)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      // [9:0] up,down,left,right,select,start,A,B,C,D [41:10] now_ms
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      // [7:0] pad_state [15:8] pad_changed [16] save [17] load [18] quit
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // turbo output for this poll; a released (or chord-consumed) key clears it
   function automatic logic turbo_phase(input logic held,
                                        inout logic [gctm_pkg::TurboWidth-1:0] frames);
      logic phase;
      if (!held) begin
         frames = '0;
         return 1'b0;
      end
      phase  = ((int'(frames) / TurboHalf) % 2) == 0;
      frames = frames + 1'b1;   // wraps at 256
      return phase;
   endfunction

   function automatic gctm_pkg::rsp_payload_type map_poll(
         inout mapper_state_type s, input gctm_pkg::req_payload_type p);
      gctm_pkg::rsp_payload_type      r;
      logic                           exit_chord, save_chord, load_chord;
      logic                           turbo_a, turbo_b, quit_now;
      logic [gctm_pkg::PadWidth-1:0]  want;
      logic [gctm_pkg::TimeWidth-1:0] elapsed;
      r          = '0;
      quit_now   = 1'b0;
      exit_chord = p.btn_select & p.btn_start;
      save_chord = p.btn_select & p.btn_c & ~p.btn_d & ~p.btn_start;
      load_chord = p.btn_select & p.btn_d & ~p.btn_c & ~p.btn_start;

      // save and load pulse on the rising edge, even once latched
      r.save_request = save_chord & ~s.save_seen;
      r.load_request = load_chord & ~s.load_seen;
      s.save_seen    = save_chord;
      s.load_seen    = load_chord;

      if (exit_chord) begin
         elapsed = p.now_ms - s.exit_t0;   // wrapping difference
         if (!s.exit_seen)
            s.exit_t0 = p.now_ms;
         else if (!s.latched &&
                  elapsed >= {{(gctm_pkg::TimeWidth-gctm_pkg::HoldWidth){1'b0}}, s.hold})
            quit_now = 1'b1;
      end else begin
         s.exit_t0 = '0;
      end

      if (quit_now) begin
         // quit poll: drop every pad, turbo and exit-chord state untouched
         s.latched      = 1'b1;
         r.pad_changed  = s.pads;
         s.pads         = '0;
         r.quit_request = 1'b1;
      end else begin
         s.exit_seen = exit_chord;
         if (!s.latched) begin
            turbo_a = turbo_phase(p.btn_c & ~save_chord & ~exit_chord, s.turbo_a);
            turbo_b = turbo_phase(p.btn_d & ~load_chord & ~exit_chord, s.turbo_b);
            want = '0;
            want[gctm_pkg::PadUp]     = p.btn_up;
            want[gctm_pkg::PadDown]   = p.btn_down;
            want[gctm_pkg::PadLeft]   = p.btn_left;
            want[gctm_pkg::PadRight]  = p.btn_right;
            want[gctm_pkg::PadSelect] = p.btn_select & ~save_chord & ~load_chord &
                                        ~exit_chord;
            want[gctm_pkg::PadStart]  = p.btn_start & ~exit_chord;
            want[gctm_pkg::PadA]      = p.btn_a | turbo_a;
            want[gctm_pkg::PadB]      = p.btn_b | turbo_b;
            r.pad_changed   = want ^ s.pads;
            s.pads          = want;
         end
      end
      r.pad_state = s.pads;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic gctm_pkg::req_payload_type make_poll(
         input logic [9:0] keys, input logic [gctm_pkg::TimeWidth-1:0] t);
      return gctm_pkg::req_payload_type'({6'd0, t, keys});
   endfunction

   // Queue one poll with its predicted report. Until the exit is wanted, a
   // poll that would fire it has start let go instead.
   task automatic send_poll(input gctm_pkg::req_payload_type poll, input bit quit_ok);
      mapper_state_type          trial;
      gctm_pkg::rsp_payload_type report;
      trial  = pad_model;
      report = map_poll(trial, poll);
      if (report.quit_request && !quit_ok) begin
         poll.btn_start = 1'b0;
         trial  = pad_model;
         report = map_poll(trial, poll);
      end
      pad_model = trial;
      pending_polls.push_back(poll);
      expected_reports.push_back(report);
      polls_sent++;
   endtask

   task automatic wait_drained();
      while (pending_polls.size() != 0 || expected_reports.size() != 0)
         @(posedge clock);
   endtask

   // hold time is only changed with the mapper idle
   task automatic write_hold(input logic [gctm_pkg::HoldWidth-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pad_model.hold = value;
      settings_used++;
   endtask

   // Mostly well-formed sequences: turbo runs, save/load chords, exit holds,
   // with random pads on top, a few corrupted polls and timestamp jumps.
   task automatic random_burst(input int count, input bit quit_ok);
      int         pushed, kind, len, step_max;
      bit         lead;
      logic [9:0] keys, keys_now;
      pushed = 0;
      while (pushed < count) begin
         kind     = $urandom_range(0, 99);
         lead     = 1'b0;
         step_max = 40;
         if (kind < 15) begin
            len  = 1;
            keys = 10'($urandom);
         end else if (kind < 40) begin
            // now and then long enough to wrap the turbo frame counter
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(257, 300)
                                               : $urandom_range(1, 24);
            case ($urandom_range(0, 2))
               0: keys = MaskC;
               1: keys = MaskD;
               default: keys = MaskC | MaskD;
            endcase
         end else if (kind < 65) begin
            len  = $urandom_range(1, 6);
            lead = $urandom_range(0, 1);
            keys = MaskSelect | ($urandom_range(0, 1) ? MaskC : MaskD);
            if ($urandom_range(0, 5) == 0)
               keys |= $urandom_range(0, 1) ? MaskStart : (MaskC | MaskD);
         end else if (kind < 88) begin
            // exit hold, time stepping on the scale of the hold setting
            len      = $urandom_range(1, 30);
            keys     = MaskSelect | MaskStart | (10'($urandom) & (MaskC | MaskD));
            step_max = int'(pad_model.hold) / 4 + 2;
         end else begin
            len       = 1;
            keys      = 10'($urandom);
            poll_time = $urandom;
         end
         for (int i = 0; i < len; i++) begin
            keys_now = ((lead && i == 0) ? MaskSelect : keys) |
                       (10'($urandom) & MaskDirs);
            if ($urandom_range(0, 3) == 0)
               keys_now |= 10'($urandom) & MaskAB;
            if ($urandom_range(0, 19) == 0)
               keys_now ^= 10'($urandom);
            poll_time += $urandom_range(0, step_max);
            send_poll(make_poll(keys_now, poll_time), quit_ok);
         end
         pushed += len;
      end
   endtask

   // -------------------------------------------------------------------------
   // Request driver: valid holds until the transaction is taken
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_polls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= pending_polls.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Long receiver hold-off, counted in cycles
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : hold_off_counter
      if (reset) begin
         hold_off_done <= 1'b0;
         hold_off_left <= 0;
      end else if (hold_off_request && !hold_off_done) begin
         hold_off_done <= 1'b1;
         hold_off_left <= HoldOffCycles;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor and receiver back-pressure
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      gctm_pkg::rsp_payload_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got          = gctm_pkg::rsp_payload_type'(rsp_tdata);
            save_pulses += got.save_request;
            load_pulses += got.load_request;
            quit_pulses += got.quit_request;
            if (expected_reports.size() == 0) begin
               if (mismatches < ReportLimit)
                  $display("unexpected report %06h with nothing outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               reports_checked++;
               if (got.pad_state    !== want.pad_state    ||
                   got.pad_changed  !== want.pad_changed  ||
                   got.save_request !== want.save_request ||
                   got.load_request !== want.load_request ||
                   got.quit_request !== want.quit_request) begin
                  if (mismatches < ReportLimit)
                     $display({"report %0d: pads exp %02h got %02h, changed exp %02h ",
                               "got %02h, save %b/%b load %b/%b quit %b/%b"},
                              reports_checked, want.pad_state, got.pad_state,
                              want.pad_changed, got.pad_changed,
                              want.save_request, got.save_request,
                              want.load_request, got.load_request,
                              want.quit_request, got.quit_request);
                  mismatches++;
               end
            end
         end

         // ready stays low through the hold-off, otherwise random stalls
         if (hold_off_left != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without any transaction on any channel
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      pad_model      = '0;
      pad_model.hold = gctm_pkg::ExitHoldReset;
      poll_time      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset hold time of 1000 ms, no idling
      send_poll(make_poll('0, 32'd0), 1'b0);
      send_poll(make_poll(MaskDirs | MaskAB, 32'hFFFF_FFFF), 1'b0);
      // every button: exit chord overrides save, load and both turbos
      send_poll(make_poll(MaskAll, 32'd5), 1'b0);
      send_poll(make_poll(MaskAll, 32'd1004), 1'b0);    // one ms short
      send_poll(make_poll('0, 32'd1010), 1'b0);
      send_poll(make_poll(MaskSelect, 32'd1011), 1'b0);
      send_poll(make_poll(MaskStart, 32'd1012), 1'b0);
      send_poll(make_poll(MaskSelect | MaskC, 32'd1013), 1'b0);           // save edge
      send_poll(make_poll(MaskSelect | MaskC, 32'd1014), 1'b0);           // held
      send_poll(make_poll(MaskSelect | MaskC | MaskD, 32'd1015), 1'b0);   // no chord
      send_poll(make_poll(MaskSelect | MaskD, 32'd1016), 1'b0);           // load edge
      // exit chord spanning the timestamp wrap, 999 ms held
      send_poll(make_poll(MaskSelect | MaskD | MaskStart, 32'hFFFF_FE00), 1'b0);
      send_poll(make_poll(MaskSelect | MaskStart, 32'h0000_0100), 1'b0);
      send_poll(make_poll(MaskSelect | MaskStart, 32'h0000_01E7), 1'b0);
      send_poll(make_poll('0, 32'h0000_01F0), 1'b0);
      // turbo A phases, then turbo B on top of a real B press
      for (int i = 0; i < 5; i++)
         send_poll(make_poll(MaskC, 32'h0000_0200 + i), 1'b0);
      send_poll(make_poll(MaskD, 32'h0000_0210), 1'b0);
      send_poll(make_poll(MaskD | MaskB, 32'h0000_0211), 1'b0);
      poll_time = 32'h0000_0300;

      // longest hold time, sender gaps
      write_hold(16'hFFFF);
      send_idle_pct <= 71;
      send_poll(make_poll(MaskSelect | MaskStart, 32'd100), 1'b0);
      send_poll(make_poll(MaskSelect | MaskStart, 32'd100 + 32'd65534), 1'b0);
      send_poll(make_poll('0, 32'd100 + 32'd65535), 1'b0);
      poll_time = 32'd70000;
      random_burst(430, 1'b0);

      // mid-range hold time, receiver stalls and one long hold-off
      write_hold(16'($urandom_range(2, 3000)));
      send_idle_pct    <= 0;
      recv_stall_pct   <= 71;
      hold_off_request <= 1'b1;
      random_burst(450, 1'b0);

      // one millisecond, no idling
      write_hold(16'd1);
      recv_stall_pct <= 0;
      random_burst(450, 1'b0);

      // zero hold: exit on the second chord poll, then the latched state
      write_hold(16'd0);
      send_idle_pct  <= 19;
      recv_stall_pct <= 19;
      random_burst(400, 1'b0);
      send_poll(make_poll(MaskDirs, poll_time + 32'd1), 1'b0);
      send_poll(make_poll(MaskDirs | MaskSelect | MaskStart, poll_time + 32'd2), 1'b0);
      send_poll(make_poll(MaskDirs | MaskSelect | MaskStart, poll_time + 32'd2), 1'b1);
      poll_time += 32'd3;
      random_burst(150, 1'b1);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Ran %0d polls over %0d exit hold settings (0, 1, mid, 1000, 65535),",
               polls_sent, settings_used);
      $display("%0d reports checked; %0d save, %0d load, %0d quit pulses seen.",
               reports_checked, save_pulses, load_pulses, quit_pulses);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d reports outstanding",
                  mismatches, expected_reports.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/gctm_pkg.sv
rtl/core/gamepad_chord_turbo_mapper_unit.sv
rtl/core/gctm_checker.sv
tb/gamepad_chord_turbo_mapper_unit_tb.sv
